### rtl/gpcb_pkg.sv
package gpcb_pkg;

  // Fixed field widths of the ports
  localparam int CELL_W    = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int RES_ROW_W = 6;
  localparam int RES_COL_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Reset value of both grid dimensions
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // Status from the search sequencer to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } gpcb_status_t;

  // One search result
  typedef struct packed {
    logic                 found;
    logic [RES_ROW_W-1:0] peak_row;
    logic [RES_COL_W-1:0] peak_col;
  } gpcb_result_t;

endpackage

### rtl/grid_peak_column_bisection.sv
// Grid peak finder by column bisection.
//
// Input channel (in_valid/in_ready): one grid cell per request, row-major,
// cell_value plus last_cell. Cells are written into an internal store at one
// request per cycle while idle. The request carrying last_cell starts the search.
// Output channel (out_valid/out_ready): one result per grid: found, peak_row,
// peak_col (row and column are zero when no peak was found).
// Configuration: cfg_wr_en writes cfg_data into num_rows (index 0) or
// num_cols (index 1); write only while the block is idle.
// Search: each bisection step reads the middle column row by row through the
// single read port of the store, plus the two neighbors. in_ready is low
// during the search.
// A finished result sits in the output register; cell loading continues
// while the receiver stalls, but a new search holds its result until the
// output register is free.
// Reset: load position returns to row 0, column 0; both dimensions become 64;
// no result is pending. The store itself is not cleared.
module grid_peak_column_bisection import gpcb_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CELL_W-1:0]    cell_value,
  input  logic                 last_cell,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 found,
  output logic [RES_ROW_W-1:0] peak_row,
  output logic [RES_COL_W-1:0] peak_col
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RN_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CN_W  = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]      num_rows;
  logic [CFG_W-1:0]      num_cols;
  logic [ROW_W-1:0]      load_row;
  logic [COL_W-1:0]      load_col;

  logic [31:0]           rows_ext;
  logic [31:0]           cols_ext;
  logic [RN_W-1:0]       rows_eff;
  logic [CN_W-1:0]       cols_eff;
  logic                  in_take;
  logic                  res_ack;
  logic [31:0]           val_ext;
  logic [VALUE_BITS-1:0] wr_data;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  gpcb_status_t          status;
  gpcb_result_t          result;

  // Clamp the dimensions into 1..MAX
  always_comb begin
    rows_ext = 32'(num_rows);
    cols_ext = 32'(num_cols);
    if (rows_ext == 32'd0) begin
      rows_ext = 32'd1;
    end else if (rows_ext > 32'(MAX_ROWS)) begin
      rows_ext = 32'(MAX_ROWS);
    end
    if (cols_ext == 32'd0) begin
      cols_ext = 32'd1;
    end else if (cols_ext > 32'(MAX_COLS)) begin
      cols_ext = 32'(MAX_COLS);
    end
    rows_eff = rows_ext[RN_W-1:0];
    cols_eff = cols_ext[CN_W-1:0];
  end

  assign in_ready = !status.busy;
  assign in_take  = in_valid && in_ready;
  assign res_ack  = status.done && (!out_valid || out_ready);

  assign val_ext = 32'(cell_value);
  assign wr_data = val_ext[VALUE_BITS-1:0];
  assign wr_addr = AW'(load_row) * AW'(MAX_COLS) + AW'(load_col);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_RESET;
      num_cols <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the load position, wrapping at the grid size; the last cell rewinds it
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row <= '0;
      load_col <= '0;
    end else if (in_take) begin
      if (last_cell) begin
        load_row <= '0;
        load_col <= '0;
      end else if ((CN_W + 1)'(load_col) + 1'b1 >= (CN_W + 1)'(cols_eff)) begin
        load_col <= '0;
        if ((RN_W + 1)'(load_row) + 1'b1 >= (RN_W + 1)'(rows_eff)) begin
          load_row <= '0;
        end else begin
          load_row <= load_row + 1'b1;
        end
      end else begin
        load_col <= load_col + 1'b1;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
      found     <= result.found;
      peak_row  <= result.peak_row;
      peak_col  <= result.peak_col;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  gpcb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_take),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gpcb_search #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (in_take && last_cell),
    .rows    (rows_eff),
    .cols    (cols_eff),
    .res_ack (res_ack),
    .status  (status),
    .result  (result),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A not-found result carries zero coordinates
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> peak_row == '0 && peak_col == '0)
    else $error("not-found result with nonzero coordinates");

  // A found column lies inside the grid
  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> 32'(peak_col) < 32'(cols_eff))
    else $error("peak column outside the grid");

  // The last cell starts a search and rewinds the load position
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_cell |=>
      !in_ready && load_row == '0 && load_col == '0)
    else $error("last cell did not start the search");

  // The store is never read while cells are being taken
  a_no_read_on_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !rd_en)
    else $error("store read during load");

endmodule

### rtl/gpcb_ram.sv
module gpcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/gpcb_search.sv
module gpcb_search import gpcb_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16,
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int RN_W  = $clog2(MAX_ROWS + 1),
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int CN_W  = $clog2(MAX_COLS + 1),
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RN_W-1:0]       rows,
  input  logic [CN_W-1:0]       cols,
  input  logic                  res_ack,
  output gpcb_status_t          status,
  output gpcb_result_t          result,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [VALUE_BITS-1:0] rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_SCAN_END,
    S_LEFT,
    S_RIGHT,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t                state;
  logic [CN_W-1:0]       lo;
  logic [CN_W-1:0]       hi_x;
  logic [COL_W-1:0]      mid;
  logic [ROW_W-1:0]      row_cnt;
  logic [VALUE_BITS-1:0] best;
  logic [ROW_W-1:0]      best_row;
  logic                  gt_left;
  logic                  lt_left;

  logic [VALUE_BITS-1:0] cmp_a;
  logic [VALUE_BITS-1:0] cmp_b;
  logic                  cmp_gt;
  logic                  cmp_lt;
  logic [ROW_W-1:0]      scan_row;
  logic                  last_row;
  logic                  take;
  logic                  left_ok;
  logic                  right_ok;
  logic [COL_W-1:0]      left_col;
  logic [COL_W-1:0]      right_col;
  logic [CN_W-1:0]       span;
  logic [COL_W-1:0]      mid_calc;
  logic [31:0]           row_ext;
  logic [31:0]           col_ext;

  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // Shared magnitude compare: scan feeds new data against the best so far,
  // the neighbor steps feed the best against the neighbor
  always_comb begin
    if (state == S_SCAN || state == S_SCAN_END) begin
      cmp_a = rd_data;
      cmp_b = best;
    end else begin
      cmp_a = best;
      cmp_b = rd_data;
    end
    cmp_gt = cmp_a > cmp_b;
    cmp_lt = cmp_a < cmp_b;
  end

  // Row whose data is on the read port during the scan
  assign scan_row = (state == S_SCAN_END) ? row_cnt : row_cnt - 1'b1;
  assign last_row = RN_W'(row_cnt) == rows - 1'b1;
  assign take     = (scan_row == '0) || cmp_gt;

  // Neighbor columns; a missing neighbor at an edge counts as smaller than any value
  assign left_ok   = mid != '0;
  assign right_ok  = ((CN_W + 1)'(mid) + 1'b1) < (CN_W + 1)'(cols);
  assign left_col  = left_ok ? mid - 1'b1 : mid;
  assign right_col = right_ok ? mid + 1'b1 : mid;

  // Midpoint of the half-open range [lo, hi_x)
  assign span     = hi_x - lo - 1'b1;
  assign mid_calc = COL_W'(lo + (span >> 1));

  assign row_ext = 32'(best_row);
  assign col_ext = 32'(mid);

  // Memory read requests
  always_comb begin
    rd_en = (state == S_SCAN) || (state == S_LEFT) || (state == S_RIGHT);
    case (state)
      S_SCAN:  rd_addr = cell_addr(row_cnt, mid);
      S_LEFT:  rd_addr = cell_addr(best_row, left_col);
      default: rd_addr = cell_addr(best_row, right_col);
    endcase
  end

  assign status.busy = state != S_IDLE;
  assign status.done = state == S_DONE;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            lo    <= '0;
            hi_x  <= cols;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (lo < hi_x) begin
            mid     <= mid_calc;
            row_cnt <= '0;
            state   <= S_SCAN;
          end else begin
            result <= '0;
            state  <= S_DONE;
          end
        end
        S_SCAN: begin
          if (row_cnt != '0 && take) begin
            best     <= rd_data;
            best_row <= scan_row;
          end
          if (last_row) begin
            state <= S_SCAN_END;
          end else begin
            row_cnt <= row_cnt + 1'b1;
          end
        end
        S_SCAN_END: begin
          if (take) begin
            best     <= rd_data;
            best_row <= scan_row;
          end
          state <= S_LEFT;
        end
        S_LEFT: begin
          state <= S_RIGHT;
        end
        S_RIGHT: begin
          gt_left <= !left_ok || cmp_gt;
          lt_left <= left_ok && cmp_lt;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (gt_left && (!right_ok || cmp_gt)) begin
            result.found    <= 1'b1;
            result.peak_row <= row_ext[RES_ROW_W-1:0];
            result.peak_col <= col_ext[RES_COL_W-1:0];
            state           <= S_DONE;
          end else if (lt_left) begin
            hi_x  <= CN_W'(mid);
            state <= S_SETUP;
          end else begin
            lo    <= CN_W'(mid) + 1'b1;
            state <= S_SETUP;
          end
        end
        S_DONE: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
